/* rtl/core/hmcd_pkg.sv */
`default_nettype none

package hmcd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [16:0] message_length;
  } out_t;

  // byte classification handed from front to back
  typedef struct packed {
    logic       first;
    logic       is_cr;
    logic       is_lf;
    logic       is_ws;
    logic       is_plus;
    logic       is_minus;
    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] lower;
  } cls_t;

  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [1:0] NUM_SKIP = 2'd0;
  localparam logic [1:0] NUM_TAKE = 2'd1;
  localparam logic [1:0] NUM_END  = 2'd2;

  localparam logic [3:0] NAME_LAST = 4'd14;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5a;
  localparam logic [7:0] CH_C     = 8'h63;

  // lower-case "content-length:"
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      4'd14:   ch = ":";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/hmcd_front.sv */
`default_nettype none

module hmcd_front
  import hmcd_pkg::*;
(
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  input  wire  q_full_i,
  output logic q_push_o,
  output cls_t q_data_o
);

  logic [7:0] b;

  assign b          = in_data_i.data_byte;
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o.first    = in_data_i.first_byte;
    q_data_o.is_cr    = (b == CH_CR);
    q_data_o.is_lf    = (b == CH_LF);
    q_data_o.is_ws    = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    q_data_o.is_plus  = (b == CH_PLUS);
    q_data_o.is_minus = (b == CH_MINUS);
    q_data_o.is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    q_data_o.digit    = b[3:0];
    q_data_o.lower    = (b >= CH_UC_A && b <= CH_UC_Z) ? (b | CH_SPACE) : b;
  end

endmodule

`default_nettype wire

/* rtl/core/hmcd_queue.sv */
`default_nettype none

module hmcd_queue
  import hmcd_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  cls_t push_data_i,
  output logic full_o,
  input  wire  pop_i,
  output logic not_empty_o,
  output cls_t pop_data_o
);

  cls_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == 2'd2);
  assign not_empty_o = (cnt_q != 2'd0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hmcd_back.sv */
`default_nettype none

module hmcd_back
  import hmcd_pkg::*;
#(
  parameter longint unsigned MAX_MESSAGE_BYTES = 65536
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  q_not_empty_i,
  input  cls_t q_data_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output out_t out_data_o
);

  localparam longint unsigned CAP = MAX_MESSAGE_BYTES + 64'd1;
  localparam int unsigned CW = $clog2(CAP + 64'd1);

  localparam logic [CW-1:0] CAP_W = CW'(CAP);
  localparam logic [CW:0]   MAX_W = (CW + 1)'(MAX_MESSAGE_BYTES);
  localparam logic [CW-1:0] MIN_BYTES = CW'(4);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    crlf_prog_q, crlf_prog_d;
  logic          lf_prog_q, lf_prog_d;
  logic          crlf_seen_q, crlf_seen_d;
  logic [CW-1:0] crlf_len_q, crlf_len_d;
  logic          lf_seen_q, lf_seen_d;
  logic [CW-1:0] lf_len_q, lf_len_d;
  logic [3:0]    name_prog_q, name_prog_d;
  logic          field_seen_q, field_seen_d;
  logic [1:0]    num_phase_q, num_phase_d;
  logic          neg_q, neg_d;
  logic [CW-1:0] body_q, body_d;

  logic eval_valid_q, eval_valid_d;
  logic out_valid_q, out_valid_d;
  out_t out_q;
  out_t eval_res;
  logic out_free;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign q_pop_o      = q_not_empty_i && (!eval_valid_q || out_free);
  assign eval_valid_d = q_pop_o || (eval_valid_q && !out_free);
  assign out_valid_d  = (eval_valid_q && out_free) || (out_valid_q && out_stall_i);
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  // state update for one popped byte
  always_comb begin
    logic [CW-1:0] cnt_b;
    logic [1:0]    crlf_prog_b;
    logic          lf_prog_b;
    logic          crlf_seen_b;
    logic          lf_seen_b;
    logic [3:0]    name_prog_b;
    logic          field_seen_b;
    logic [1:0]    num_phase_b;
    logic          neg_b;
    logic [CW-1:0] body_b;
    logic [CW+3:0] prod;

    cnt_d        = cnt_q;
    crlf_prog_d  = crlf_prog_q;
    lf_prog_d    = lf_prog_q;
    crlf_seen_d  = crlf_seen_q;
    crlf_len_d   = crlf_len_q;
    lf_seen_d    = lf_seen_q;
    lf_len_d     = lf_len_q;
    name_prog_d  = name_prog_q;
    field_seen_d = field_seen_q;
    num_phase_d  = num_phase_q;
    neg_d        = neg_q;
    body_d       = body_q;

    cnt_b        = cnt_q;
    crlf_prog_b  = crlf_prog_q;
    lf_prog_b    = lf_prog_q;
    crlf_seen_b  = crlf_seen_q;
    lf_seen_b    = lf_seen_q;
    name_prog_b  = name_prog_q;
    field_seen_b = field_seen_q;
    num_phase_b  = num_phase_q;
    neg_b        = neg_q;
    body_b       = body_q;
    prod         = '0;

    if (q_pop_o) begin
      // new message starts from a cleared state
      if (q_data_i.first) begin
        cnt_b        = '0;
        crlf_prog_b  = 2'd0;
        lf_prog_b    = 1'b0;
        crlf_seen_b  = 1'b0;
        lf_seen_b    = 1'b0;
        name_prog_b  = 4'd0;
        field_seen_b = 1'b0;
        num_phase_b  = NUM_SKIP;
        neg_b        = 1'b0;
        body_b       = '0;
        crlf_len_d   = '0;
        lf_len_d     = '0;
      end

      cnt_d = (cnt_b < CAP_W) ? cnt_b + CW'(1) : cnt_b;

      num_phase_d = num_phase_b;
      neg_d       = neg_b;
      body_d      = body_b;
      prod = ({4'd0, body_b} << 3) + ({4'd0, body_b} << 1) + (CW + 4)'(q_data_i.digit);
      if (field_seen_b) begin
        unique case (num_phase_b)
          NUM_SKIP: begin
            priority if (q_data_i.is_ws) begin
              num_phase_d = NUM_SKIP;
            end else if (q_data_i.is_plus) begin
              num_phase_d = NUM_TAKE;
            end else if (q_data_i.is_minus) begin
              neg_d       = 1'b1;
              num_phase_d = NUM_TAKE;
            end else if (q_data_i.is_digit) begin
              body_d      = CW'(q_data_i.digit);
              num_phase_d = NUM_TAKE;
            end else begin
              num_phase_d = NUM_END;
            end
          end
          NUM_TAKE: begin
            if (q_data_i.is_digit) begin
              body_d = (prod > (CW + 4)'(CAP)) ? CAP_W : prod[CW-1:0];
            end else begin
              num_phase_d = NUM_END;
            end
          end
          default: begin
            num_phase_d = num_phase_b;
          end
        endcase
      end

      crlf_seen_d = crlf_seen_b;
      crlf_prog_d = crlf_prog_b;
      if (!crlf_seen_b) begin
        unique case (crlf_prog_b)
          2'd0: crlf_prog_d = q_data_i.is_cr ? 2'd1 : 2'd0;
          2'd1: crlf_prog_d = q_data_i.is_lf ? 2'd2 : (q_data_i.is_cr ? 2'd1 : 2'd0);
          2'd2: crlf_prog_d = q_data_i.is_cr ? 2'd3 : 2'd0;
          default: begin
            if (q_data_i.is_lf) begin
              crlf_seen_d = 1'b1;
              crlf_len_d  = cnt_d;
              crlf_prog_d = 2'd0;
            end else begin
              crlf_prog_d = q_data_i.is_cr ? 2'd1 : 2'd0;
            end
          end
        endcase
      end

      lf_seen_d = lf_seen_b;
      lf_prog_d = lf_prog_b;
      if (!lf_seen_b) begin
        if (q_data_i.is_lf) begin
          if (lf_prog_b) begin
            lf_seen_d = 1'b1;
            lf_len_d  = cnt_d;
            lf_prog_d = 1'b0;
          end else begin
            lf_prog_d = 1'b1;
          end
        end else begin
          lf_prog_d = 1'b0;
        end
      end

      field_seen_d = field_seen_b;
      name_prog_d  = name_prog_b;
      if (!field_seen_b) begin
        if (q_data_i.lower == name_char(name_prog_b)) begin
          if (name_prog_b == NAME_LAST) begin
            field_seen_d = 1'b1;
            name_prog_d  = 4'd0;
          end else begin
            name_prog_d = name_prog_b + 4'd1;
          end
        end else begin
          name_prog_d = (q_data_i.lower == CH_C) ? 4'd1 : 4'd0;
        end
      end
    end
  end

  // completeness check on the state left by the last byte
  always_comb begin
    logic [CW-1:0] head;
    logic [CW-1:0] body_eff;
    logic [CW:0]   total;
    logic          neg_bad;

    head     = crlf_seen_q ? crlf_len_q : lf_len_q;
    body_eff = (field_seen_q && !neg_q) ? body_q : '0;
    neg_bad  = field_seen_q && neg_q && (body_q != '0);
    total    = {1'b0, head} + {1'b0, body_eff};

    eval_res.status         = ST_MORE;
    eval_res.message_length = 17'd0;
    if ((cnt_q >= MIN_BYTES) && (crlf_seen_q || lf_seen_q)) begin
      priority if (neg_bad || (total > MAX_W)) begin
        eval_res.status = ST_BAD;
      end else if ({1'b0, cnt_q} >= total) begin
        eval_res.status         = ST_DONE;
        eval_res.message_length = 17'(total);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_valid_q && out_free) begin
      out_q <= eval_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      crlf_prog_q  <= 2'd0;
      lf_prog_q    <= 1'b0;
      crlf_seen_q  <= 1'b0;
      crlf_len_q   <= '0;
      lf_seen_q    <= 1'b0;
      lf_len_q     <= '0;
      name_prog_q  <= 4'd0;
      field_seen_q <= 1'b0;
      num_phase_q  <= NUM_SKIP;
      neg_q        <= 1'b0;
      body_q       <= '0;
      eval_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      crlf_prog_q  <= crlf_prog_d;
      lf_prog_q    <= lf_prog_d;
      crlf_seen_q  <= crlf_seen_d;
      crlf_len_q   <= crlf_len_d;
      lf_seen_q    <= lf_seen_d;
      lf_len_q     <= lf_len_d;
      name_prog_q  <= name_prog_d;
      field_seen_q <= field_seen_d;
      num_phase_q  <= num_phase_d;
      neg_q        <= neg_d;
      body_q       <= body_d;
      eval_valid_q <= eval_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/http_message_completeness_detector_unit.sv */
`default_nettype none

// Content-Length framing detector for HTTP requests. One byte is taken per
// transfer and exactly one status transfer comes back for every byte, in order:
// need more bytes, complete with the header-plus-body length, or bad (negative
// or over MAX_MESSAGE_BYTES). Setting first_byte starts a new message. The
// block sustains one byte per cycle while the output is not stalled; a byte's
// result is offered after the transfer writes the classified byte into a
// two-entry queue, then the matcher and length update, then the completeness
// check into the output register. Input stall rises only when the queue is
// full.
module http_message_completeness_detector_unit
  import hmcd_pkg::*;
#(
  parameter longint unsigned MAX_MESSAGE_BYTES = 65536
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output out_t out_data_o
);

  logic q_full;
  logic q_push;
  cls_t q_wdata;
  logic q_pop;
  logic q_not_empty;
  cls_t q_rdata;

  hmcd_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  hmcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .pop_data_o  (q_rdata)
  );

  hmcd_back #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

`default_nettype wire
